// ----- src/interrupt_table_entry_parser_core_defines.svh -----
// ----------------------------------------------------------------------------
// Interrupt table entry parser: assertion macros
// Shared property shorthands for the modules that check their own logic.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_TABLE_ENTRY_PARSER_CORE_DEFINES_SVH
`define INTERRUPT_TABLE_ENTRY_PARSER_CORE_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define ITEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ITEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/itep_pkg.sv -----
// ----------------------------------------------------------------------------
// Interrupt table entry parser: package
// Record layout, field codes and fixed table constants.
// ----------------------------------------------------------------------------
`default_nettype none

package itep_pkg;

  localparam int unsigned LEN_W = 21;

  // table header layout
  localparam logic [LEN_W-1:0] HEADER_END    = 21'd44;
  localparam logic [LEN_W-1:0] LOCAL_ADDR_AT = 21'd36;
  localparam logic [LEN_W-1:0] DEFAULT_LIMIT = 21'd1048576;

  localparam logic [7:0] SIG_CHARS [4] = '{8'h41, 8'h50, 8'h49, 8'h43};

  // entry types and the shortest entry that carries a full record
  localparam logic [7:0] ENTRY_IO       = 8'd1;
  localparam logic [7:0] ENTRY_OVR      = 8'd2;
  localparam logic [7:0] ENTRY_LADDR    = 8'd5;
  localparam logic [7:0] IO_MIN_SIZE    = 8'd12;
  localparam logic [7:0] OVR_MIN_SIZE   = 8'd10;
  localparam logic [7:0] LADDR_MIN_SIZE = 8'd12;

  // record kinds
  localparam logic [1:0] KIND_IO   = 2'd0;
  localparam logic [1:0] KIND_OVR  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIG   = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_BAD_SUM   = 3'd3;
  localparam logic [2:0] ST_BAD_ENTRY = 3'd4;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ident;
    logic [31:0] word_value;
    logic [31:0] gsi_base;
    logic [15:0] irq_flags;
    logic [63:0] local_address;
    logic [2:0]  status;
    logic        ready_res;
    logic        last;
  } res_t;

  // records produced for one byte: p0 first slot, p1 second slot
  typedef struct packed {
    logic p0;
    logic p1;
  } push_t;

endpackage

`default_nettype wire

// ----- src/itep_in_if.sv -----
// ----------------------------------------------------------------------------
// Interrupt table entry parser: byte input channel
// Valid/ready channel carrying one table byte and its start flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface itep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

`default_nettype wire

// ----- src/itep_out_if.sv -----
// ----------------------------------------------------------------------------
// Interrupt table entry parser: record output channel
// Valid/ready channel carrying one parsed record.
// ----------------------------------------------------------------------------
`default_nettype none

interface itep_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  ident;
  logic [31:0] word_value;
  logic [31:0] gsi_base;
  logic [15:0] irq_flags;
  logic [63:0] local_address;
  logic [2:0]  status;
  logic        ready_res;
  logic        last;

  modport source (
    output valid, output kind, output ident, output word_value, output gsi_base,
    output irq_flags, output local_address, output status, output ready_res,
    output last, input ready
  );
  modport sink (
    input valid, input kind, input ident, input word_value, input gsi_base,
    input irq_flags, input local_address, input status, input ready_res,
    input last, output ready
  );
endinterface

`default_nettype wire

// ----- src/itep_parse.sv -----
// ----------------------------------------------------------------------------
// Interrupt table entry parser: byte parser
// Holds the table state and turns one byte into up to two records.
// ----------------------------------------------------------------------------
`default_nettype none

`include "interrupt_table_entry_parser_core_defines.svh"

module itep_parse #(
  parameter int unsigned MAX_IO_CTRL      = 16,
  parameter int unsigned MAX_OVERRIDES    = 16,
  parameter int unsigned ENTRY_KEEP_BYTES = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        go,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        start_req,
  input  wire logic [itep_pkg::LEN_W-1:0]  max_len,
  output itep_pkg::push_t                  push,
  output itep_pkg::res_t                   res0,
  output itep_pkg::res_t                   res1
);
  import itep_pkg::*;

  localparam int unsigned IO_W   = $clog2(MAX_IO_CTRL + 1);
  localparam int unsigned OVR_W  = $clog2(MAX_OVERRIDES + 1);
  localparam int unsigned KEEP_W = $clog2(ENTRY_KEEP_BYTES);

  logic              active_r;
  logic [LEN_W-1:0]  idx_r;
  logic [31:0]       tlen_r;
  logic [7:0]        sum_r;
  logic              sig_r;
  logic [7:0]        eb_r [ENTRY_KEEP_BYTES];
  logic [LEN_W-1:0]  neo_r;
  logic [7:0]        ekind_r;
  logic [7:0]        esize_r;
  logic [IO_W-1:0]   io_cnt_r;
  logic [OVR_W-1:0]  ov_cnt_r;
  logic [63:0]       laddr_r;
  logic [2:0]        perr_r;

  logic              proc;
  logic [LEN_W-1:0]  c_idx, c_neo, rel;
  logic [31:0]       c_tlen, neo32;
  logic [7:0]        c_sum, c_ekind, c_esize;
  logic              c_sig;
  logic [IO_W-1:0]   c_io;
  logic [OVR_W-1:0]  c_ov;
  logic [63:0]       c_laddr, laddr_hdr;
  logic [2:0]        c_perr;

  logic [LEN_W-1:0]  idx_nxt, neo_nxt;
  logic [31:0]       tlen_nxt;
  logic [7:0]        sum_nxt, ekind_nxt, esize_nxt;
  logic              sig_nxt;
  logic [IO_W-1:0]   io_cnt_nxt;
  logic [OVR_W-1:0]  ov_cnt_nxt;
  logic [63:0]       laddr_nxt;
  logic [2:0]        perr_nxt;

  logic              match, bad_sig, bad_len, early, walk, keep_wr, fin;
  logic              io_hit, ov_hit, la_hit, rec_v, done_v, rdy;
  logic [KEEP_W-1:0] rel_idx;
  logic [7:0]        eb_cur [ENTRY_KEEP_BYTES];
  logic [31:0]       w4, w8;
  logic [2:0]        status;
  res_t              rec, done_rec;

  // a start flag sees the cleared table
  always_comb begin
    c_idx   = start_req ? '0 : idx_r;
    c_tlen  = start_req ? '0 : tlen_r;
    c_sum   = start_req ? '0 : sum_r;
    c_sig   = start_req ? 1'b0 : sig_r;
    c_neo   = start_req ? HEADER_END : neo_r;
    c_ekind = start_req ? '0 : ekind_r;
    c_esize = start_req ? '0 : esize_r;
    c_io    = start_req ? '0 : io_cnt_r;
    c_ov    = start_req ? '0 : ov_cnt_r;
    c_laddr = start_req ? '0 : laddr_r;
    c_perr  = start_req ? ST_OK : perr_r;
    proc    = go && (start_req || active_r);
  end

  // header fields
  always_comb begin
    sum_nxt   = c_sum + data_byte;
    sig_nxt   = c_sig;
    tlen_nxt  = c_tlen;
    laddr_hdr = c_laddr;
    match     = 1'b0;
    bad_sig   = 1'b0;
    bad_len   = 1'b0;
    if (c_idx < 21'd4) begin
      match   = (data_byte == SIG_CHARS[c_idx[1:0]]);
      sig_nxt = (c_idx == '0) ? match : (c_sig && match);
      bad_sig = (c_idx == 21'd3) && !sig_nxt;
    end else if (c_idx < 21'd8) begin
      tlen_nxt[{c_idx[1:0], 3'b000} +: 8] = data_byte;
      bad_len = (c_idx == 21'd7) &&
                ((tlen_nxt < 32'(HEADER_END)) || (tlen_nxt > {11'b0, max_len}));
    end else if (c_idx >= LOCAL_ADDR_AT && c_idx < LOCAL_ADDR_AT + 21'd4) begin
      laddr_hdr[{c_idx[1:0], 3'b000} +: 8] = data_byte;
    end
    early = bad_sig || bad_len;
  end

  // entry walk
  always_comb begin
    neo32     = {11'b0, c_neo};
    walk      = !early && (c_perr == ST_OK) && (c_idx >= c_neo) &&
                (neo32 + 32'd2 <= c_tlen);
    rel       = c_idx - c_neo;
    keep_wr   = walk && (rel < 21'(ENTRY_KEEP_BYTES));
    rel_idx   = rel[KEEP_W-1:0];
    ekind_nxt = c_ekind;
    esize_nxt = c_esize;
    perr_nxt  = c_perr;
    fin       = 1'b0;
    if (walk) begin
      if (rel == '0) begin
        ekind_nxt = data_byte;
      end else begin
        if (rel == 21'd1) begin
          esize_nxt = data_byte;
          if (data_byte < 8'd2 || {24'b0, data_byte} > c_tlen - neo32) begin
            perr_nxt = ST_BAD_ENTRY;
          end
        end
        fin = (perr_nxt == ST_OK) && (esize_nxt != '0) &&
              (rel == {13'b0, esize_nxt} - 21'd1);
      end
    end
  end

  // entry bytes with this byte forwarded
  always_comb begin
    for (int k = 0; k < ENTRY_KEEP_BYTES; k++) begin
      eb_cur[k] = eb_r[k];
    end
    if (keep_wr) begin
      eb_cur[rel_idx] = data_byte;
    end
  end

  assign w4 = {eb_cur[7], eb_cur[6], eb_cur[5], eb_cur[4]};
  assign w8 = {eb_cur[11], eb_cur[10], eb_cur[9], eb_cur[8]};

  always_comb begin
    io_hit = fin && (c_ekind == ENTRY_IO) && (esize_nxt >= IO_MIN_SIZE) &&
             (c_io < IO_W'(MAX_IO_CTRL));
    ov_hit = fin && (c_ekind == ENTRY_OVR) && (esize_nxt >= OVR_MIN_SIZE) &&
             (eb_cur[2] == 8'd0) && (c_ov < OVR_W'(MAX_OVERRIDES));
    la_hit = fin && (c_ekind == ENTRY_LADDR) && (esize_nxt >= LADDR_MIN_SIZE);
    rec_v  = io_hit || ov_hit;

    io_cnt_nxt = io_hit ? c_io + IO_W'(1) : c_io;
    ov_cnt_nxt = ov_hit ? c_ov + OVR_W'(1) : c_ov;
    laddr_nxt  = la_hit ? {w8, w4} : laddr_hdr;
    neo_nxt    = fin ? c_neo + {13'b0, esize_nxt} : c_neo;
    idx_nxt    = c_idx + 21'd1;

    done_v = early || ((c_idx >= 21'd7) && ({11'b0, c_idx} + 32'd1 == tlen_nxt));
    if (bad_sig) begin
      status = ST_BAD_SIG;
    end else if (bad_len) begin
      status = ST_BAD_LEN;
    end else if (sum_nxt != 8'd0) begin
      status = ST_BAD_SUM;
    end else begin
      status = perr_nxt;
    end
    rdy = (status == ST_OK) && (laddr_nxt != '0) && (io_cnt_nxt != '0);
  end

  always_comb begin
    rec               = '0;
    rec.kind          = io_hit ? KIND_IO : KIND_OVR;
    rec.ident         = io_hit ? eb_cur[2] : eb_cur[3];
    rec.word_value    = w4;
    rec.gsi_base      = io_hit ? w8 : 32'd0;
    rec.irq_flags     = io_hit ? 16'd0 : {eb_cur[9], eb_cur[8]};
    rec.status        = ST_OK;
    rec.last          = !done_v;

    done_rec               = '0;
    done_rec.kind          = KIND_DONE;
    done_rec.local_address = laddr_nxt;
    done_rec.status        = status;
    done_rec.ready_res     = rdy;
    done_rec.last          = 1'b1;

    push.p0 = proc && (rec_v || done_v);
    push.p1 = proc && rec_v && done_v;
    res0    = rec_v ? rec : done_rec;
    res1    = done_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
      tlen_r   <= '0;
      sum_r    <= '0;
      sig_r    <= 1'b0;
      neo_r    <= HEADER_END;
      ekind_r  <= '0;
      esize_r  <= '0;
      io_cnt_r <= '0;
      ov_cnt_r <= '0;
      laddr_r  <= '0;
      perr_r   <= ST_OK;
    end else if (proc) begin
      active_r <= !done_v;
      idx_r    <= idx_nxt;
      tlen_r   <= tlen_nxt;
      sum_r    <= sum_nxt;
      sig_r    <= sig_nxt;
      neo_r    <= neo_nxt;
      ekind_r  <= ekind_nxt;
      esize_r  <= esize_nxt;
      io_cnt_r <= io_cnt_nxt;
      ov_cnt_r <= ov_cnt_nxt;
      laddr_r  <= laddr_nxt;
      perr_r   <= perr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && keep_wr) begin
      eb_r[rel_idx] <= data_byte;
    end
  end

  `ITEP_ASSERT_NOW(a_done_second, push.p1, res1.kind == KIND_DONE && res0.kind != KIND_DONE, "second record is not the done record")
  `ITEP_ASSERT_NEXT(a_done_closes, push.p0 && done_v, !active_r, "table still active after done record")
  `ITEP_ASSERT_NOW(a_ready_ok, push.p0 && res0.ready_res, res0.status == ST_OK, "ready flag with error status")

endmodule

`default_nettype wire

// ----- src/itep_rfifo.sv -----
// ----------------------------------------------------------------------------
// Interrupt table entry parser: record queue
// Four-deep record queue taking up to two records a cycle, giving one.
// ----------------------------------------------------------------------------
`default_nettype none

`include "interrupt_table_entry_parser_core_defines.svh"

module itep_rfifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  itep_pkg::push_t      push,
  input  itep_pkg::res_t       d0,
  input  itep_pkg::res_t       d1,
  input  wire logic            pop,
  output itep_pkg::res_t       head,
  output logic                 head_valid,
  output logic                 space2
);
  import itep_pkg::*;

  res_t               q_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r, wp_nxt, rp_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;

  assign head       = q_r[rp_r];
  assign head_valid = (cnt_r != '0);
  assign space2     = (cnt_r <= FIFO_CW'(FIFO_DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + FIFO_AW'(push.p0) + FIFO_AW'(push.p1);
    rp_nxt  = rp_r + FIFO_AW'(pop);
    cnt_nxt = cnt_r + FIFO_CW'(push.p0) + FIFO_CW'(push.p1) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.p0) begin
      q_r[wp_r] <= d0;
    end
    if (push.p1) begin
      q_r[wp_r + FIFO_AW'(1)] <= d1;
    end
  end

  `ITEP_ASSERT_NOW(a_no_overflow, push.p0, cnt_r <= FIFO_CW'(FIFO_DEPTH - 2), "record queue overflow")
  `ITEP_ASSERT_NOW(a_pair_order, push.p1, push.p0, "second slot pushed without first")
  `ITEP_ASSERT_NEXT(a_drain, pop && !push.p0, cnt_r == $past(cnt_r) - FIFO_CW'(1), "queue count did not drop on pop")

endmodule

`default_nettype wire

// ----- src/interrupt_table_entry_parser_core.sv -----
// ----------------------------------------------------------------------------
// Interrupt table entry parser: top level
// Streams an interrupt controller description table and emits records.
// ----------------------------------------------------------------------------
// The block takes one table byte per cycle, back to back. A byte is held in
// an input register, parsed in a single pass against the table state and
// its records land in a four-deep record queue, from whose registered head
// they are offered to the sink. A byte may raise two records (an entry
// finishing on the last table byte); the queue takes both together, so
// input only stalls when the sink falls behind and the queue has fewer than
// two free slots. Records for I/O controllers and overrides are provisional
// until the done record reports the checksum. The length limit register is
// to be written between tables.
`default_nettype none

module interrupt_table_entry_parser_core #(
  parameter int unsigned MAX_IO_CTRL      = 16,
  parameter int unsigned MAX_OVERRIDES    = 16,
  parameter int unsigned ENTRY_KEEP_BYTES = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  itep_in_if.sink                          in_ch,
  itep_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [itep_pkg::LEN_W-1:0]  cfg_wdata
);
  import itep_pkg::*;

  logic [LEN_W-1:0] max_len_r;
  logic             s1_v_r;
  logic [7:0]       s1_byte_r;
  logic             s1_start_r;
  logic             go, space2, head_valid, in_acc;
  push_t            push;
  res_t             res0, res1, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= DEFAULT_LIMIT;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  // advance the input word only when the queue can take two records
  assign go          = s1_v_r && space2;
  assign in_ch.ready = !s1_v_r || go;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r  <= in_ch.data_byte;
      s1_start_r <= in_ch.start_req;
    end
  end

  itep_parse #(
    .MAX_IO_CTRL      (MAX_IO_CTRL),
    .MAX_OVERRIDES    (MAX_OVERRIDES),
    .ENTRY_KEEP_BYTES (ENTRY_KEEP_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .data_byte (s1_byte_r),
    .start_req (s1_start_r),
    .max_len   (max_len_r),
    .push      (push),
    .res0      (res0),
    .res1      (res1)
  );

  itep_rfifo u_rfifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .d0         (res0),
    .d1         (res1),
    .pop        (head_valid && out_ch.ready),
    .head       (head),
    .head_valid (head_valid),
    .space2     (space2)
  );

  assign out_ch.valid         = head_valid;
  assign out_ch.kind          = head.kind;
  assign out_ch.ident         = head.ident;
  assign out_ch.word_value    = head.word_value;
  assign out_ch.gsi_base      = head.gsi_base;
  assign out_ch.irq_flags     = head.irq_flags;
  assign out_ch.local_address = head.local_address;
  assign out_ch.status        = head.status;
  assign out_ch.ready_res     = head.ready_res;
  assign out_ch.last          = head.last;

endmodule

`default_nettype wire

// ----- test/tb_interrupt_table_entry_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interrupt table entry parser: testbench
// Builds interrupt controller description tables byte by byte and streams
// them through the parser. A behavioural copy of the parser predicts every
// record, and each record taken from the output is compared field by field.
// Covers header faults, entry records, entry length faults, restarts, the
// length limit register, the record count limits and output back-pressure.
// ----------------------------------------------------------------------------

module tb_interrupt_table_entry_parser_core;
  import itep_pkg::*;

  localparam int IO_LIMIT     = 16;
  localparam int OVR_LIMIT    = 16;
  localparam int KEEP_BYTES   = 12;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 300000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [LEN_W-1:0]     cfg_wdata;

  itep_in_if  in_if ();
  itep_out_if out_if ();

  interrupt_table_entry_parser_core #(
    .MAX_IO_CTRL      (IO_LIMIT),
    .MAX_OVERRIDES    (OVR_LIMIT),
    .ENTRY_KEEP_BYTES (KEEP_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // parser copy: limit register and table state
  logic [LEN_W-1:0] max_len;
  logic [LEN_W-1:0] byte_pos;
  logic [31:0]      hdr_len;
  logic [7:0]       sum_acc;
  bit               sig_match;
  logic [7:0]       ent_buf [KEEP_BYTES];
  logic [LEN_W-1:0] ent_start;
  logic [7:0]       ent_type;
  logic [7:0]       ent_len;
  int               io_seen;
  int               ovr_seen;
  logic [63:0]      lapic_addr;
  logic [2:0]       walk_err;
  bit               in_table;

  res_t        pending_records [$];
  logic [7:0]  tbl [$];

  bit  idle_on;
  int  hold_left;
  int  cycle_count;
  int  mismatches;
  int  bytes_sent;
  int  tables_sent;
  int  records_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_table_state();
    byte_pos   = '0;
    hdr_len    = '0;
    sum_acc    = '0;
    sig_match  = 1'b0;
    foreach (ent_buf[k]) ent_buf[k] = '0;
    ent_start  = HEADER_END;
    ent_type   = '0;
    ent_len    = '0;
    io_seen    = 0;
    ovr_seen   = 0;
    lapic_addr = '0;
    walk_err   = ST_OK;
  endfunction

  function automatic logic [31:0] ent_word(int at);
    return {ent_buf[at+3], ent_buf[at+2], ent_buf[at+1], ent_buf[at]};
  endfunction

  function automatic res_t table_done_record(logic [2:0] st);
    res_t r;
    r = '0;
    r.kind          = KIND_DONE;
    r.local_address = lapic_addr;
    r.status        = st;
    r.ready_res     = (st == ST_OK && lapic_addr != 0 && io_seen != 0);
    in_table = 1'b0;
    return r;
  endfunction

  // returns 1 when the finished entry yields a record
  function automatic bit close_entry(output res_t r);
    r = '0;
    if (ent_type == ENTRY_IO && ent_len >= IO_MIN_SIZE && io_seen < IO_LIMIT) begin
      io_seen++;
      r.kind       = KIND_IO;
      r.ident      = ent_buf[2];
      r.word_value = ent_word(4);
      r.gsi_base   = ent_word(8);
      return 1'b1;
    end
    if (ent_type == ENTRY_OVR && ent_len >= OVR_MIN_SIZE && ent_buf[2] == 8'd0 &&
        ovr_seen < OVR_LIMIT) begin
      ovr_seen++;
      r.kind       = KIND_OVR;
      r.ident      = ent_buf[3];
      r.word_value = ent_word(4);
      r.irq_flags  = {ent_buf[9], ent_buf[8]};
      return 1'b1;
    end
    if (ent_type == ENTRY_LADDR && ent_len >= LADDR_MIN_SIZE)
      lapic_addr = {ent_word(8), ent_word(4)};
    return 1'b0;
  endfunction

  function automatic void parse_table_byte(logic [7:0] b, logic st);
    res_t             rec [2];
    res_t             r;
    int               n;
    bit               stop;
    logic [LEN_W-1:0] i;
    logic [31:0]      rel;
    n = 0;
    stop = 1'b0;
    if (st) begin
      clear_table_state();
      in_table = 1'b1;
    end else if (!in_table) begin
      return;
    end
    i = byte_pos;
    sum_acc = sum_acc + b;

    if (i < 4) begin
      sig_match = (b == SIG_CHARS[i[1:0]]) && (i == 0 || sig_match);
      if (i == 3 && !sig_match) begin
        rec[n] = table_done_record(ST_BAD_SIG);
        n++;
        stop = 1'b1;
      end
    end else if (i < 8) begin
      hdr_len[8*i[1:0] +: 8] = b;
      if (i == 7 && (hdr_len < 32'(HEADER_END) || hdr_len > 32'(max_len))) begin
        rec[n] = table_done_record(ST_BAD_LEN);
        n++;
        stop = 1'b1;
      end
    end else if (i >= LOCAL_ADDR_AT && i < LOCAL_ADDR_AT + 21'd4) begin
      lapic_addr[8*i[1:0] +: 8] = b;
    end

    if (!stop) begin
      // walk the entries once the header is behind us
      if (walk_err == ST_OK && i >= ent_start && 64'(ent_start) + 64'd2 <= 64'(hdr_len)) begin
        rel = 32'(i - ent_start);
        if (rel < KEEP_BYTES)
          ent_buf[rel] = b;
        if (rel == 0) begin
          ent_type = b;
        end else begin
          if (rel == 1) begin
            ent_len = b;
            if (b < 8'd2 || 32'(b) > hdr_len - 32'(ent_start))
              walk_err = ST_BAD_ENTRY;
          end
          if (walk_err == ST_OK && rel == 32'(ent_len) - 32'd1) begin
            if (close_entry(r)) begin
              rec[n] = r;
              n++;
            end
            ent_start = ent_start + LEN_W'(ent_len);
          end
        end
      end
      if (i >= 7 && 64'(i) + 64'd1 == 64'(hdr_len)) begin
        rec[n] = table_done_record(sum_acc != 0 ? ST_BAD_SUM :
                                   (walk_err != ST_OK ? ST_BAD_ENTRY : ST_OK));
        n++;
      end
      byte_pos = i + 1'b1;
    end

    if (n > 0)
      rec[n-1].last = 1'b1;
    for (int k = 0; k < n; k++)
      pending_records.push_back(rec[k]);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(string name, logic [63:0] want, logic [63:0] seen);
    if (want !== seen) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      records_seen++;
      if (pending_records.size() == 0) begin
        $display("%0t: record kind %0h expected none actual one", $time, out_if.kind);
        mismatches++;
      end else begin
        want = pending_records.pop_front();
        check_field("kind", want.kind, out_if.kind);
        check_field("ident", want.ident, out_if.ident);
        check_field("word_value", want.word_value, out_if.word_value);
        check_field("gsi_base", want.gsi_base, out_if.gsi_base);
        check_field("irq_flags", want.irq_flags, out_if.irq_flags);
        check_field("local_address", want.local_address, out_if.local_address);
        check_field("status", want.status, out_if.status);
        check_field("ready_res", want.ready_res, out_if.ready_res);
        check_field("last", want.last, out_if.last);
      end
    end
  end

  // record sink: random stalls, plus a long hold when asked for
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_if.ready = !idle_on || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic send_byte(logic [7:0] b, logic st);
    if (idle_on && $urandom_range(0, 99) < 8) begin
      @(negedge clk);
      in_if.valid     = 1'b0;
      in_if.data_byte = 8'($urandom);
      in_if.start_req = 1'($urandom);
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid     = 1'b1;
    in_if.data_byte = b;
    in_if.start_req = st;
    // hold the word until it is taken
    do @(posedge clk); while (in_if.ready !== 1'b1);
    parse_table_byte(b, st);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid     = 1'b0;
    in_if.start_req = 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(logic [LEN_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    max_len = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ---------------------------------------------------------------- table building

  function automatic void begin_table(logic [31:0] lapic);
    tbl.delete();
    for (int k = 0; k < 4; k++) tbl.push_back(SIG_CHARS[k]);
    // length and checksum are patched when the table is sealed
    for (int k = 4; k < 36; k++) tbl.push_back(8'($urandom));
    for (int k = 0; k < 4; k++) tbl.push_back(lapic[8*k +: 8]);
    for (int k = 0; k < 4; k++) tbl.push_back(8'($urandom));
  endfunction

  function automatic int add_entry(logic [7:0] kind, int size);
    int pos;
    pos = tbl.size();
    tbl.push_back(kind);
    tbl.push_back(8'(size));
    for (int k = 2; k < size; k++) tbl.push_back(8'($urandom));
    if (kind == ENTRY_OVR && size > 2 && $urandom_range(0, 6) != 0)
      tbl[pos+2] = 8'd0;
    return pos;
  endfunction

  function automatic void seal_table(logic [31:0] len, bit good_sum);
    logic [7:0] s;
    int         top;
    for (int k = 0; k < 4; k++) tbl[4+k] = len[8*k +: 8];
    tbl[9] = 8'd0;
    s = 8'd0;
    top = (len < tbl.size()) ? int'(len) : tbl.size();
    for (int k = 0; k < top; k++) s = s + tbl[k];
    tbl[9] = 8'd0 - s;
    if (!good_sum)
      tbl[9] = tbl[9] + 8'($urandom_range(1, 255));
  endfunction

  task automatic send_table(int count);
    for (int k = 0; k < count; k++) send_byte(tbl[k], k == 0);
    tables_sent++;
  endtask

  task automatic send_random_table();
    int          n_ent;
    int          pick;
    int          sz;
    int          pos;
    int          mode;
    int          count;
    logic [7:0]  kind;
    logic [31:0] len;
    begin_table(($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom));
    n_ent = $urandom_range(0, 6);
    for (int k = 0; k < n_ent; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        kind = ENTRY_IO;
        sz = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 16) : 12;
      end else if (pick < 65) begin
        kind = ENTRY_OVR;
        sz = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 14) : 10;
      end else if (pick < 75) begin
        kind = ENTRY_LADDR;
        sz = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 16) : 12;
      end else begin
        kind = 8'($urandom);
        sz = $urandom_range(2, 20);
      end
      void'(add_entry(kind, sz));
    end
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      // broken entry: too short or running past the table end
      pos = add_entry(8'($urandom_range(0, 5)), $urandom_range(2, 12));
      if ($urandom_range(0, 1) == 0)
        tbl[pos+1] = 8'($urandom_range(0, 1));
      else
        tbl[pos+1] = 8'(tbl.size() - pos + $urandom_range(1, 30));
    end else if (mode < 13) begin
      tbl.push_back(8'($urandom));
    end
    len = tbl.size();
    if (mode >= 13 && mode < 18) begin
      case ($urandom_range(0, 2))
        0:       len = $urandom_range(0, 43);
        1:       len = 32'(max_len) + $urandom_range(1, 1000);
        default: len = 32'hFFFF_F000 | $urandom_range(0, 4095);
      endcase
    end
    seal_table(len, $urandom_range(0, 9) != 0);
    if (mode >= 18 && mode < 22) begin
      pos = $urandom_range(0, 3);
      tbl[pos] = tbl[pos] ^ 8'($urandom_range(1, 255));
    end
    count = tbl.size();
    if (mode >= 22 && mode < 27)
      count = $urandom_range(1, tbl.size() - 1);
    send_table(count);
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_stray_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(SIG_CHARS[0], 1'b0);
    repeat (4) send_byte(8'($urandom), 1'b0);
    wait_drained();
  endtask

  task automatic test_header_errors();
    logic [31:0] bad_lens [4];
    bad_lens = '{32'd0, 32'd43, 32'(DEFAULT_LIMIT) + 32'd1, 32'hFFFF_FFFF};
    for (int k = 0; k < 4; k++) begin
      begin_table(32'($urandom));
      seal_table(tbl.size(), 1'b1);
      tbl[k] = tbl[k] ^ 8'h20;
      send_table(tbl.size());
    end
    foreach (bad_lens[k]) begin
      begin_table(32'($urandom));
      seal_table(bad_lens[k], 1'b1);
      send_table(tbl.size());
    end
    // header only, with good and bad checksum
    begin_table(32'hFEE0_0000);
    seal_table(tbl.size(), 1'b1);
    send_table(tbl.size());
    begin_table(32'hFEE0_0000);
    seal_table(tbl.size(), 1'b0);
    send_table(tbl.size());
    wait_drained();
  endtask

  task automatic test_entry_records();
    int pos;
    begin_table(32'hFEC0_0000);
    pos = add_entry(ENTRY_IO, 12);
    for (int k = 2; k < 12; k++) tbl[pos+k] = 8'hFF;
    pos = add_entry(ENTRY_IO, 12);
    for (int k = 2; k < 12; k++) tbl[pos+k] = 8'h00;
    void'(add_entry(ENTRY_IO, 16));
    pos = add_entry(ENTRY_OVR, 10);
    tbl[pos+2] = 8'h00;
    pos = add_entry(ENTRY_OVR, 10);
    tbl[pos+2] = 8'h03;                 // not bus zero: skipped
    void'(add_entry(ENTRY_LADDR, 12));
    void'(add_entry(ENTRY_IO, 11));     // too short for a record
    void'(add_entry(ENTRY_OVR, 9));
    void'(add_entry(ENTRY_LADDR, 11));
    void'(add_entry(8'hC8, 7));
    void'(add_entry(8'h00, 2));
    tbl.push_back(8'($urandom));        // lone tail byte
    seal_table(tbl.size(), 1'b1);
    send_table(tbl.size());

    // no local address; entry closes on the last byte, giving two records
    begin_table(32'd0);
    void'(add_entry(ENTRY_IO, 12));
    seal_table(tbl.size(), 1'b1);
    send_table(tbl.size());

    // local address cleared by an entry, no I/O controller
    begin_table(32'($urandom) | 32'd1);
    pos = add_entry(ENTRY_LADDR, 12);
    for (int k = 4; k < 12; k++) tbl[pos+k] = 8'h00;
    pos = add_entry(ENTRY_OVR, 10);
    tbl[pos+2] = 8'h00;
    seal_table(tbl.size(), 1'b1);
    send_table(tbl.size());

    // records stay provisional when the checksum fails
    begin_table(32'hFEE0_0000);
    void'(add_entry(ENTRY_IO, 12));
    void'(add_entry(ENTRY_LADDR, 14));
    seal_table(tbl.size(), 1'b0);
    send_table(tbl.size());
    wait_drained();
  endtask

  task automatic test_entry_length_errors();
    int pos;
    for (int z = 0; z < 2; z++) begin
      begin_table(32'hFEE0_0000);
      void'(add_entry(ENTRY_IO, 12));
      pos = add_entry(ENTRY_IO, 12);
      tbl[pos+1] = 8'(z);
      void'(add_entry(ENTRY_IO, 12));
      seal_table(tbl.size(), 1'b1);
      send_table(tbl.size());
    end
    // entry running past the end, with good then bad checksum
    for (int g = 1; g >= 0; g--) begin
      begin_table(32'hFEE0_0000);
      void'(add_entry(ENTRY_IO, 12));
      pos = add_entry(ENTRY_OVR, 10);
      tbl[pos+1] = 8'(tbl.size() - pos + 1);
      seal_table(tbl.size(), g[0]);
      send_table(tbl.size());
    end
    wait_drained();
  endtask

  task automatic test_restart();
    begin_table(32'hFEE0_0000);
    repeat (3) void'(add_entry(ENTRY_IO, 12));
    seal_table(tbl.size(), 1'b1);
    send_table(tbl.size() - 5);
    send_table(2);
    // largest length the default limit allows; cut short by the next start
    begin_table(32'hFEE0_0000);
    repeat (2) void'(add_entry(ENTRY_IO, 12));
    seal_table(32'(DEFAULT_LIMIT), 1'b1);
    send_table(tbl.size());
    begin_table(32'hFEE0_0000);
    void'(add_entry(ENTRY_IO, 12));
    seal_table(tbl.size(), 1'b1);
    send_table(tbl.size());
    // bytes after the done record are dropped
    repeat (3) send_byte(8'($urandom), 1'b0);
    wait_drained();
  endtask

  task automatic test_limit_register();
    write_limit(HEADER_END);
    begin_table(32'hFEE0_0000);
    seal_table(tbl.size(), 1'b1);
    send_table(tbl.size());
    begin_table(32'hFEE0_0000);
    tbl.push_back(8'($urandom));
    seal_table(tbl.size(), 1'b1);
    send_table(tbl.size());
    write_limit(LEN_W'($urandom_range(45, 120)));
    repeat (3) send_random_table();
    write_limit(DEFAULT_LIMIT);
    begin_table(32'hFEE0_0000);
    seal_table(tbl.size(), 1'b1);
    send_table(tbl.size());
    wait_drained();
  endtask

  task automatic test_count_limits_backpressure();
    int pos;
    begin_table(32'($urandom) | 32'h100);
    repeat (IO_LIMIT + 2) void'(add_entry(ENTRY_IO, 12));
    repeat (OVR_LIMIT + 2) begin
      pos = add_entry(ENTRY_OVR, 10);
      tbl[pos+2] = 8'h00;
    end
    seal_table(tbl.size(), 1'b1);
    // stall the sink long enough for the record queue to fill up
    hold_left = 400;
    send_table(tbl.size());
    wait_drained();
  endtask

  task automatic test_random_tables();
    int goal;
    int t;
    goal = bytes_sent + 1100;
    t = 0;
    while (bytes_sent < goal) begin
      idle_on = !(t >= 6 && t < 10);
      if (t > 0 && $urandom_range(0, 99) < 12) begin
        case ($urandom_range(0, 3))
          0:       write_limit(HEADER_END);
          1:       write_limit(DEFAULT_LIMIT);
          2:       write_limit(LEN_W'($urandom_range(44, 200)));
          default: write_limit(LEN_W'($urandom_range(44, 1048576)));
        endcase
      end
      send_random_table();
      t++;
    end
    idle_on = 1'b1;
    wait_drained();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.start_req = 1'b0;
    idle_on         = 1'b1;
    hold_left       = 0;
    cycle_count     = 0;
    mismatches      = 0;
    bytes_sent      = 0;
    tables_sent     = 0;
    records_seen    = 0;
    max_len         = DEFAULT_LIMIT;
    in_table        = 1'b0;
    clear_table_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_stray_bytes();
    test_header_errors();
    test_entry_records();
    test_entry_length_errors();
    test_restart();
    test_limit_register();
    test_count_limits_backpressure();
    test_random_tables();
    wait_drained();

    mismatches = mismatches + pending_records.size();
    $display("Streamed %0d table bytes in %0d tables and checked %0d records,",
             bytes_sent, tables_sent, records_seen);
    $display("covering header faults, entry faults, restarts, limits and back-pressure.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
